// ===== hdl/fnv_hash_combine_seed_macros.svh =====
// Assertion macros shared by the seed generator modules.
`ifndef FNV_HASH_COMBINE_SEED_MACROS_SVH
`define FNV_HASH_COMBINE_SEED_MACROS_SVH
`ifndef SYNTHESIS
`define FHCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define FHCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FHCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define FHCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/fnv_hcs_pkg.sv =====
// Types, constants and hash functions of the seed generator.
package fnv_hcs_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned HASH_W = 64;
  localparam int unsigned LANES  = 3;

  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [HASH_W-1:0] GOLDEN    = 64'h000000009e3779b9;
  localparam logic [WORD_W-1:0] DEP_XOR   = 32'h9e3779bd;
  localparam logic [WORD_W-1:0] DEP_SUB   = 32'h53a3c768;
  localparam logic [WORD_W-1:0] ARR_XOR   = 32'h9e3779bc;
  localparam logic [WORD_W-1:0] ARR_SUB   = 32'h53a3c728;
  localparam logic [WORD_W-1:0] TAG_DEP   = 32'd4;
  localparam logic [WORD_W-1:0] TAG_ARR   = 32'd3;
  localparam logic [WORD_W-1:0] TAG_IDLE  = 32'd9;

  typedef enum logic [2:0] {
    KIND_DEP    = 3'd0,
    KIND_ARR    = 3'd1,
    KIND_TIME   = 3'd2,
    KIND_IDLE   = 3'd3,
    KIND_ENTITY = 3'd4,
    KIND_NATIVE = 3'd5
  } kind_t;

  typedef struct packed {
    logic use3;
    logic zero;
  } ctl_t;

  typedef struct packed {
    ctl_t                           ctl;
    logic [LANES-1:0][WORD_W-1:0]   word;
    logic [LANES-1:0][HASH_W-1:0]   hash;
  } stage_t;

  // One FNV-1a byte step; the prime 2^40 + 0x1b3 is applied as shifts and adds.
  function automatic logic [HASH_W-1:0] fnv_byte(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] b);
    logic [HASH_W-1:0] hx;
    hx = h ^ {{(HASH_W-8){1'b0}}, b};
    return hx + (hx << 40) + (hx << 8) + (hx << 7) + (hx << 5) + (hx << 4)
           + (hx << 1);
  endfunction

  function automatic logic [HASH_W-1:0] mix(input logic [HASH_W-1:0] seed,
                                             input logic [HASH_W-1:0] h);
    return seed ^ (h + GOLDEN + (seed << 6) + (seed >> 2));
  endfunction

endpackage

// ===== hdl/fnv_hcs_ifs.sv =====
// Valid/ready channel interfaces for request and result items.
interface fnv_hcs_in_if;
  import fnv_hcs_pkg::*;

  logic                valid;
  logic                ready;
  logic [2:0]          kind;
  logic [WORD_W-1:0]   tag_value;
  logic [WORD_W-1:0]   time_or_native;
  logic [WORD_W-1:0]   entity_value;
  logic [HASH_W-1:0]   mixed_intermediate;
  logic                mixed_flag;

  modport source (output valid, kind, tag_value, time_or_native, entity_value,
                  mixed_intermediate, mixed_flag, input ready);
  modport sink (input valid, kind, tag_value, time_or_native, entity_value,
                mixed_intermediate, mixed_flag, output ready);
endinterface

interface fnv_hcs_out_if;
  import fnv_hcs_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] seed_out;

  modport source (output valid, seed_out, input ready);
  modport sink (input valid, seed_out, output ready);
endinterface

// ===== hdl/fnv_hash_combine_seed.sv =====
// Top level of the pipelined FNV-1a hash-combine seed generator.
//
//   channel  direction  handshake            payload
//   in_ch    sink       valid/ready          kind, tag_value, time_or_native,
//                                            entity_value, mixed_intermediate,
//                                            mixed_flag
//   out_ch   source     valid/ready          seed_out
//
// Each item passes nine register stages: decode, operand select, four byte
// steps of the hash lanes, and three combine steps.
// A new item is accepted in every cycle while the result side takes items.
// A stage that holds an item takes a new one only when its successor moves, so
// a stall fills the pipeline from the output back and loses nothing.
// Reset clears only the valid bits of the stages.
`include "fnv_hash_combine_seed_macros.svh"

module fnv_hash_combine_seed (
  input  logic          clk,
  input  logic          rst_n,
  fnv_hcs_in_if.sink    in_ch,
  fnv_hcs_out_if.source out_ch
);
  import fnv_hcs_pkg::*;

  // Stage 1: decode and the long subtractions of the from-native mode.
  logic              s1_valid_r;
  logic              s1_ready;
  logic [2:0]        s1_kind_r;
  logic [WORD_W-1:0] s1_tag_r;
  logic [WORD_W-1:0] s1_tn_r;
  logic [WORD_W-1:0] s1_ent_r;
  logic [WORD_W-1:0] s1_t01_r;
  logic [HASH_W-1:0] s1_x_r;
  logic [HASH_W-1:0] s1_f_r;
  logic [WORD_W-1:0] s1_t01_nxt;
  logic [HASH_W-1:0] s1_x_nxt;
  logic [HASH_W-1:0] s1_f_nxt;
  logic [HASH_W-1:0] sext_ent;

  // Stage 2: operand selection.
  logic              s2_valid_r;
  logic              s2_ready;
  stage_t            s2_data_r;
  stage_t            s2_data_nxt;
  logic [HASH_W-1:0] s2_o;
  logic [WORD_W-1:0] s2_t5;

  // Byte stages.
  logic   [4:0] b_valid;
  logic   [4:0] b_ready;
  stage_t       b_data [5];

  // Combine stages.
  logic              s7_valid_r;
  logic              s7_ready;
  ctl_t              s7_ctl_r;
  logic [HASH_W-1:0] s7_seed_r;
  logic [HASH_W-1:0] s7_hb_r;
  logic [HASH_W-1:0] s7_hc_r;
  logic              s8_valid_r;
  logic              s8_ready;
  ctl_t              s8_ctl_r;
  logic [HASH_W-1:0] s8_seed_r;
  logic [HASH_W-1:0] s8_hc_r;
  logic [HASH_W-1:0] s8_seed_nxt;
  logic              out_valid_r;
  logic              out_ready_int;
  logic [WORD_W-1:0] out_seed_r;
  logic [HASH_W-1:0] out_full;
  logic [WORD_W-1:0] out_seed_nxt;

  // Ready chain from the output back to the input.
  assign out_ready_int = !out_valid_r || out_ch.ready;
  assign s8_ready      = !s8_valid_r || out_ready_int;
  assign s7_ready      = !s7_valid_r || s8_ready;
  assign b_ready[4]    = s7_ready;
  assign s2_ready      = !s2_valid_r || b_ready[0];
  assign s1_ready      = !s1_valid_r || s2_ready;
  assign in_ch.ready   = s1_ready;

  // Stage 1.
  always_comb begin
    sext_ent = {{(HASH_W-WORD_W){in_ch.entity_value[WORD_W-1]}}, in_ch.entity_value};
    if (in_ch.kind == KIND_ARR) begin
      s1_t01_nxt = (in_ch.time_or_native ^ ARR_XOR) - ARR_SUB;
    end else begin
      s1_t01_nxt = (in_ch.time_or_native ^ DEP_XOR) - DEP_SUB;
    end
    if (in_ch.mixed_flag) begin
      s1_x_nxt = (in_ch.mixed_intermediate - sext_ent - GOLDEN) >> 6;
    end else begin
      s1_x_nxt = in_ch.mixed_intermediate;
    end
    s1_f_nxt = GOLDEN + {{(HASH_W-WORD_W){1'b0}}, in_ch.tag_value};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_ch.valid) begin
      s1_kind_r <= in_ch.kind;
      s1_tag_r  <= in_ch.tag_value;
      s1_tn_r   <= in_ch.time_or_native;
      s1_ent_r  <= in_ch.entity_value;
      s1_t01_r  <= s1_t01_nxt;
      s1_x_r    <= s1_x_nxt;
      s1_f_r    <= s1_f_nxt;
    end
  end

  // Stage 2.
  always_comb begin
    s2_o  = GOLDEN + (s1_f_r << 6) + (s1_f_r >> 2);
    s2_t5 = WORD_W'((s1_x_r ^ s1_f_r) - s2_o);
    s2_data_nxt.ctl.use3 = 1'b0;
    s2_data_nxt.ctl.zero = 1'b0;
    s2_data_nxt.word[0]  = s1_tag_r;
    s2_data_nxt.word[1]  = s1_tn_r;
    s2_data_nxt.word[2]  = s1_ent_r;
    for (int i = 0; i < LANES; i++) begin
      s2_data_nxt.hash[i] = FNV_BASIS;
    end
    case (s1_kind_r)
      KIND_DEP: begin
        s2_data_nxt.word[0] = TAG_DEP;
        s2_data_nxt.word[1] = s1_t01_r;
      end
      KIND_ARR: begin
        s2_data_nxt.word[0] = TAG_ARR;
        s2_data_nxt.word[1] = s1_t01_r;
      end
      KIND_TIME: begin
      end
      KIND_IDLE: begin
        s2_data_nxt.word[0]  = TAG_IDLE;
        s2_data_nxt.ctl.use3 = 1'b1;
      end
      KIND_ENTITY: begin
        s2_data_nxt.ctl.use3 = 1'b1;
      end
      KIND_NATIVE: begin
        s2_data_nxt.word[1]  = s2_t5;
        s2_data_nxt.ctl.use3 = 1'b1;
      end
      default: begin
        s2_data_nxt.ctl.zero = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_data_r <= s2_data_nxt;
    end
  end

  assign b_valid[0] = s2_valid_r;
  assign b_data[0]  = s2_data_r;

  // Stages 3 to 6: one byte of every word per stage.
  for (genvar g = 0; g < 4; g++) begin : g_byte
    fnv_hcs_byte_stage u_byte (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (b_valid[g]),
      .up_ready (b_ready[g]),
      .up_data  (b_data[g]),
      .dn_valid (b_valid[g+1]),
      .dn_ready (b_ready[g+1]),
      .dn_data  (b_data[g+1])
    );
  end

  // Stage 7: the first combine step starts from a zero seed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_valid_r <= 1'b0;
    end else if (s7_ready) begin
      s7_valid_r <= b_valid[4];
    end
  end

  always_ff @(posedge clk) begin
    if (s7_ready && b_valid[4]) begin
      s7_ctl_r  <= b_data[4].ctl;
      s7_seed_r <= b_data[4].hash[0] + GOLDEN;
      s7_hb_r   <= b_data[4].hash[1];
      s7_hc_r   <= b_data[4].hash[2];
    end
  end

  // Stage 8.
  assign s8_seed_nxt = mix(s7_seed_r, s7_hb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_valid_r <= 1'b0;
    end else if (s8_ready) begin
      s8_valid_r <= s7_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s8_ready && s7_valid_r) begin
      s8_ctl_r  <= s7_ctl_r;
      s8_seed_r <= s8_seed_nxt;
      s8_hc_r   <= s7_hc_r;
    end
  end

  // Stage 9: the third value is chained only in the three-value modes.
  always_comb begin
    if (s8_ctl_r.use3) begin
      out_full = mix(s8_seed_r, s8_hc_r);
    end else begin
      out_full = s8_seed_r;
    end
    if (s8_ctl_r.zero) begin
      out_seed_nxt = '0;
    end else begin
      out_seed_nxt = out_full[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready_int) begin
      out_valid_r <= s8_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready_int && s8_valid_r) begin
      out_seed_r <= out_seed_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.seed_out = out_seed_r;

  `FHCS_ASSERT_NEXT(a_in_load, clk, rst_n, in_ch.valid && in_ch.ready, s1_valid_r, "accepted item not in first stage")
  `FHCS_ASSERT_NEXT(a_zero_kind, clk, rst_n, s8_valid_r && s8_ctl_r.zero && out_ready_int, out_valid_r && out_seed_r == '0, "unused mode gave a nonzero seed")
  `FHCS_ASSERT_NOW(a_full_stall, clk, rst_n, !out_ch.ready && out_valid_r && s8_valid_r && s7_valid_r && (&b_valid) && s1_valid_r, !in_ch.ready, "input taken while pipeline is full and stalled")

endmodule

// ===== hdl/fnv_hcs_byte_stage.sv =====
// One pipeline stage that applies an FNV-1a byte step to all three hash lanes.
`include "fnv_hash_combine_seed_macros.svh"

module fnv_hcs_byte_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  fnv_hcs_pkg::stage_t  up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output fnv_hcs_pkg::stage_t  dn_data
);
  import fnv_hcs_pkg::*;

  logic   valid_r;
  stage_t data_r;
  stage_t data_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // The low byte of each word is consumed here and the word moves down a byte.
  always_comb begin
    data_nxt.ctl = up_data.ctl;
    for (int i = 0; i < LANES; i++) begin
      data_nxt.word[i] = up_data.word[i] >> 8;
      data_nxt.hash[i] = fnv_byte(up_data.hash[i], up_data.word[i][7:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  `FHCS_ASSERT_NEXT(a_load, clk, rst_n, up_valid && up_ready, valid_r, "item lost on load")
  `FHCS_ASSERT_NEXT(a_hold, clk, rst_n, valid_r && !dn_ready, valid_r && $stable(data_r), "stalled item changed")
  `FHCS_ASSERT_NOW(a_shift, clk, rst_n, valid_r, data_r.word[0][31:24] == 8'd0 && data_r.word[1][31:24] == 8'd0 && data_r.word[2][31:24] == 8'd0, "word not shifted")

endmodule
